// File: sv/fvm_pkg.sv
// Shared constants and codes for the fisheye vertex mapper.
`timescale 1ns / 1ps
`default_nettype none

package fvm_pkg;

  // CORDIC datapath fraction bits and gain start value (Q30)
  localparam int INT_FRAC = 30;
  localparam int ATAN_N = 24;
  localparam logic [31:0] CORDIC_GAIN = 32'd652032874;

  // atan(2^-i) as a 32-bit turn fraction
  localparam logic [31:0] ATAN_TURN32 [ATAN_N] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41721, 32'd20860,
    32'd10430, 32'd5215, 32'd2607, 32'd1303, 32'd651, 32'd325, 32'd162, 32'd81
  };

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HALF_FOV         = 2'd0,
    CFG_REFLECT_NEG      = 2'd1,
    CFG_SQUARE_HALF_SIDE = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    OP_RING   = 1'b0,
    OP_SQUARE = 1'b1
  } op_e;

endpackage

`default_nettype wire

// File: sv/fvm_ifs.sv
// Handshake channel interfaces: vertex input, mapped result, register writes.
`timescale 1ns / 1ps
`default_nettype none

interface fvm_vtx_if #(
  parameter int RADIUS_W = 15,
  parameter int ANGLE_W  = 16
);
  logic                valid;
  logic                ready;
  logic                opcode;
  logic [RADIUS_W-1:0] radius;
  logic [ANGLE_W-1:0]  angle;

  modport source (output valid, opcode, radius, angle, input ready);
  modport sink   (input valid, opcode, radius, angle, output ready);
endinterface

interface fvm_res_if #(
  parameter int POS_W = 19,
  parameter int DIR_W = 16
);
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic signed [DIR_W-1:0] dir_x;
  logic signed [DIR_W-1:0] dir_y;
  logic signed [DIR_W-1:0] dir_z;

  modport source (output valid, pos_x, pos_y, dir_x, dir_y, dir_z, input ready);
  modport sink   (input valid, pos_x, pos_y, dir_x, dir_y, dir_z, output ready);
endinterface

interface fvm_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [fvm_pkg::CFG_IDX_W-1:0]   index;
  logic [fvm_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: sv/fisheye_vertex_mapper.sv
// Fisheye vertex mapper: pipelined CORDIC, product and divider datapath.
// Usage:
//   vtx_i  (sink)   : opcode, radius, angle of one vertex per transfer.
//   res_o  (source) : pos_x, pos_y, dir_x, dir_y, dir_z, one result per vertex.
//   cfg_i  (sink)   : register writes (index, data); always ready. Write only
//                     while no vertex is in flight.
// From input transfer to output valid an item passes through the input and
// fisheye angle multiply stages, CORDIC_STAGES + 1 rotation stages (two
// CORDICs side by side), round and product stages, then FRAC_BITS + 6 stages
// of a radix-2 restoring divider for the square edge quotient, and the output
// register.
// Throughput is one vertex per cycle unless res_o is held; every stage advances together.
// When res_o is held (valid high, ready low) the whole pipe freezes and
// vtx_i.ready drops in the same cycle; nothing is dropped or repeated.
// Reset clears all valid bits and loads the registers: half_fov = half turn,
// reflect_neg = 0, square_half_side = 1.0. No clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module fisheye_vertex_mapper #(
  parameter int FRAC_BITS     = 14,
  parameter int ANGLE_BITS    = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  fvm_cfg_if.sink       cfg_i,
  fvm_vtx_if.sink       vtx_i,
  fvm_res_if.source     res_o
);
  import fvm_pkg::*;

  localparam int FB   = FRAC_BITS;
  localparam int AB   = ANGLE_BITS;
  localparam int NS   = CORDIC_STAGES;
  localparam int RW   = FB + 1;
  localparam int PW   = FB + 5;
  localparam int DW   = FB + 2;
  localparam int SW   = FB + 4;
  localparam int BW   = AB + 1;
  localparam int XW   = 33;
  localparam int ZW   = 34;
  localparam int SH   = INT_FRAC - FB;
  localparam int MW   = 2 * FB + 4;
  localparam int NUMW = SW + 1 + DW;
  localparam int NW   = 2 * FB + 6;
  localparam int DVW  = FB + 2;
  localparam int QN   = PW;

  localparam logic signed [XW-1:0] HALF_X  = XW'(1) << (SH - 1);
  localparam logic signed [XW-1:0] ONE_X   = XW'(1) << FB;
  localparam logic signed [XW-1:0] NONE_X  = -ONE_X;
  localparam logic signed [DW-1:0] ONE_D   = DW'(1) << FB;
  localparam logic signed [DW-1:0] NONE_D  = -ONE_D;
  localparam logic signed [MW-1:0] HALF_M  = MW'(1) << (FB - 1);

  typedef struct packed {
    logic          op;
    logic [RW-1:0] r;
    logic [1:0]    qa;
    logic [1:0]    qb;
    logic          ring_ok;
    logic          refl;
    logic [SW-1:0] side;
  } ctl_t;

  typedef struct packed {
    logic                 op;
    logic                 sel;
    logic                 neg;
    logic                 dz;
    logic                 refl;
    logic                 ring_ok;
    logic signed [SW:0]   fixed;
    logic signed [PW-1:0] rpx;
    logic signed [PW-1:0] rpy;
    logic signed [DW-1:0] rdx;
    logic signed [DW-1:0] rdz;
    logic signed [DW-1:0] cb;
  } res_t;

  function automatic logic signed [DW-1:0] rnd_clamp(input logic signed [XW-1:0] v);
    logic signed [XW-1:0] t;
    t = (v + HALF_X) >>> SH;
    if (t > ONE_X) return ONE_D;
    if (t < NONE_X) return NONE_D;
    return DW'(t);
  endfunction

  // returns {sin, cos} after quadrant rotation
  function automatic logic [2*DW-1:0] quad_rot(input logic [1:0] q,
                                               input logic signed [DW-1:0] s,
                                               input logic signed [DW-1:0] c);
    logic [2*DW-1:0] res;
    case (q)
      2'd0:    res = {s, c};
      2'd1:    res = {c, DW'(-s)};
      2'd2:    res = {DW'(-s), DW'(-c)};
      default: res = {DW'(-c), s};
    endcase
    return res;
  endfunction

  function automatic logic signed [MW-1:0] mulq_rnd(input logic signed [MW-1:0] m);
    return (m + HALF_M) >>> FB;
  endfunction

  // ---------------- configuration ----------------
  logic [AB-1:0] half_fov_q;
  logic          reflect_q;
  logic [SW-1:0] side_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_fov_q <= AB'(1) << (AB - 1);
      reflect_q  <= 1'b0;
      side_q     <= SW'(1) << FB;
    end else if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.index))
        CFG_HALF_FOV:         half_fov_q <= cfg_i.data[AB-1:0];
        CFG_REFLECT_NEG:      reflect_q  <= cfg_i.data[0];
        CFG_SQUARE_HALF_SIDE: side_q     <= cfg_i.data[SW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- pipeline control ----------------
  logic en;
  logic out_vld_q;

  assign en          = !out_vld_q || res_o.ready;
  assign vtx_i.ready = en;

  logic          p1_vld_q, p2_vld_q, p3_vld_q, p4_vld_q;
  logic [NS:0]   cvld_q;
  logic [QN:0]   dvld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_vld_q  <= 1'b0;
      p2_vld_q  <= 1'b0;
      cvld_q    <= '0;
      p3_vld_q  <= 1'b0;
      p4_vld_q  <= 1'b0;
      dvld_q    <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      p1_vld_q  <= vtx_i.valid;
      p2_vld_q  <= p1_vld_q;
      cvld_q    <= {cvld_q[NS-1:0], p2_vld_q};
      p3_vld_q  <= cvld_q[NS];
      p4_vld_q  <= p3_vld_q;
      dvld_q    <= {dvld_q[QN-1:0], p4_vld_q};
      out_vld_q <= dvld_q[QN];
    end
  end

  // ---------------- stage 1: input register ----------------
  logic          p1_op_q;
  logic [RW-1:0] p1_r_q;
  logic [AB-1:0] p1_ang_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_op_q  <= vtx_i.opcode;
      p1_r_q   <= vtx_i.radius;
      p1_ang_q <= vtx_i.angle;
    end
  end

  // ---------------- stage 2: fisheye angle b = r * half_fov ----------------
  logic [RW+AB-1:0] b_prod;
  logic [BW-1:0]    b_d;
  ctl_t             p2_ctl_d, p2_ctl_q;
  logic [AB-3:0]    p2_za_q, p2_zb_q;

  always_comb begin
    b_prod           = p1_r_q * half_fov_q;
    b_d              = b_prod[RW+AB-1:FB];
    p2_ctl_d.op      = p1_op_q;
    p2_ctl_d.r       = p1_r_q;
    p2_ctl_d.qa      = p1_ang_q[AB-1:AB-2];
    p2_ctl_d.qb      = b_d[AB-1:AB-2];
    p2_ctl_d.ring_ok = (b_d[BW-1:AB-1] == '0);
    p2_ctl_d.refl    = reflect_q;
    p2_ctl_d.side    = side_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p2_ctl_q <= p2_ctl_d;
      p2_za_q  <= p1_ang_q[AB-3:0];
      p2_zb_q  <= b_d[AB-3:0];
    end
  end

  // ---------------- CORDIC stages (angle a and angle b) ----------------
  logic signed [XW-1:0] cxa_q [NS+1];
  logic signed [XW-1:0] cya_q [NS+1];
  logic signed [ZW-1:0] cza_q [NS+1];
  logic signed [XW-1:0] cxb_q [NS+1];
  logic signed [XW-1:0] cyb_q [NS+1];
  logic signed [ZW-1:0] czb_q [NS+1];
  ctl_t                 cctl_q [NS+1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      cxa_q[0]  <= XW'(CORDIC_GAIN);
      cya_q[0]  <= '0;
      cza_q[0]  <= ZW'(p2_za_q) << (32 - AB);
      cxb_q[0]  <= XW'(CORDIC_GAIN);
      cyb_q[0]  <= '0;
      czb_q[0]  <= ZW'(p2_zb_q) << (32 - AB);
      cctl_q[0] <= p2_ctl_q;
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_cordic
    localparam logic signed [ZW-1:0] AT = ZW'(ATAN_TURN32[i]);
    logic signed [XW-1:0] xa_d, ya_d, xb_d, yb_d;
    logic signed [ZW-1:0] za_d, zb_d;

    always_comb begin
      if (!cza_q[i][ZW-1]) begin
        xa_d = cxa_q[i] - (cya_q[i] >>> i);
        ya_d = cya_q[i] + (cxa_q[i] >>> i);
        za_d = cza_q[i] - AT;
      end else begin
        xa_d = cxa_q[i] + (cya_q[i] >>> i);
        ya_d = cya_q[i] - (cxa_q[i] >>> i);
        za_d = cza_q[i] + AT;
      end
      if (!czb_q[i][ZW-1]) begin
        xb_d = cxb_q[i] - (cyb_q[i] >>> i);
        yb_d = cyb_q[i] + (cxb_q[i] >>> i);
        zb_d = czb_q[i] - AT;
      end else begin
        xb_d = cxb_q[i] + (cyb_q[i] >>> i);
        yb_d = cyb_q[i] - (cxb_q[i] >>> i);
        zb_d = czb_q[i] + AT;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        cxa_q[i+1]  <= xa_d;
        cya_q[i+1]  <= ya_d;
        cza_q[i+1]  <= za_d;
        cxb_q[i+1]  <= xb_d;
        cyb_q[i+1]  <= yb_d;
        czb_q[i+1]  <= zb_d;
        cctl_q[i+1] <= cctl_q[i];
      end
    end
  end

  // ---------------- stage 3: round, clamp, quadrant ----------------
  logic signed [DW-1:0] sa_d, ca_d, sb_d, cb_d;
  logic signed [DW-1:0] sa_q, ca_q, sb_q, cb_q;
  ctl_t                 p3_ctl_q;

  always_comb begin
    {sa_d, ca_d} = quad_rot(cctl_q[NS].qa, rnd_clamp(cya_q[NS]), rnd_clamp(cxa_q[NS]));
    {sb_d, cb_d} = quad_rot(cctl_q[NS].qb, rnd_clamp(cyb_q[NS]), rnd_clamp(cxb_q[NS]));
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sa_q     <= sa_d;
      ca_q     <= ca_d;
      sb_q     <= sb_d;
      cb_q     <= cb_d;
      p3_ctl_q <= cctl_q[NS];
    end
  end

  // ---------------- stage 4: products and square edge setup ----------------
  logic signed [RW:0]     rs;
  logic signed [MW-1:0]   m_px, m_py, m_dx, m_dz;
  logic signed [DW-1:0]   as_w, ac_w;
  logic                   sel_d;
  logic signed [SW:0]     sidep, fixed_d;
  logic signed [NUMW-1:0] num_d, num_q;
  logic signed [DW-1:0]   den_d, den_q;
  res_t                   p4_res_d, p4_res_q;

  always_comb begin
    rs    = signed'({1'b0, p3_ctl_q.r});
    m_px  = mulq_rnd(rs * ca_q);
    m_py  = mulq_rnd(rs * sa_q);
    m_dx  = mulq_rnd(sb_q * ca_q);
    m_dz  = mulq_rnd(sb_q * sa_q);
    as_w  = sa_q[DW-1] ? -sa_q : sa_q;
    ac_w  = ca_q[DW-1] ? -ca_q : ca_q;
    sel_d = as_w > ac_w;
    sidep = signed'({1'b0, p3_ctl_q.side});
    if (sel_d) begin
      fixed_d = (sa_q > 0) ? sidep : -sidep;
      num_d   = fixed_d * ca_q;
      den_d   = sa_q;
    end else begin
      fixed_d = (ca_q > 0) ? sidep : -sidep;
      num_d   = fixed_d * sa_q;
      den_d   = ca_q;
    end
    p4_res_d.op      = p3_ctl_q.op;
    p4_res_d.sel     = sel_d;
    p4_res_d.neg     = 1'b0;
    p4_res_d.dz      = 1'b0;
    p4_res_d.refl    = p3_ctl_q.refl;
    p4_res_d.ring_ok = p3_ctl_q.ring_ok;
    p4_res_d.fixed   = fixed_d;
    p4_res_d.rpx     = PW'(m_px);
    p4_res_d.rpy     = PW'(m_py);
    p4_res_d.rdx     = DW'(m_dx);
    p4_res_d.rdz     = DW'(m_dz);
    p4_res_d.cb      = cb_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      num_q    <= num_d;
      den_q    <= den_d;
      p4_res_q <= p4_res_d;
    end
  end

  // ---------------- divider: q = (2|n| + |d|) / (2|d|) ----------------
  logic [NUMW-1:0] un;
  logic [DW-1:0]   ud;
  logic [NW-1:0]   n_d;
  logic [DVW-1:0]  dv_d;
  res_t            dv_res_d;

  logic [NW-1:0]   dv_rem_q [QN+1];
  logic [QN-1:0]   dv_quo_q [QN+1];
  logic [DVW-1:0]  dv_den_q [QN+1];
  res_t            dv_res_q [QN+1];

  always_comb begin
    un           = num_q[NUMW-1] ? NUMW'(-num_q) : NUMW'(num_q);
    ud           = den_q[DW-1] ? DW'(-den_q) : DW'(den_q);
    n_d          = (NW'(un) << 1) + NW'(ud);
    dv_d         = DVW'(ud) << 1;
    dv_res_d     = p4_res_q;
    dv_res_d.neg = num_q[NUMW-1] != den_q[DW-1];
    dv_res_d.dz  = (den_q == '0);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_rem_q[0] <= n_d;
      dv_quo_q[0] <= '0;
      dv_den_q[0] <= dv_d;
      dv_res_q[0] <= dv_res_d;
    end
  end

  for (genvar k = 0; k < QN; k++) begin : g_div
    localparam int BI = QN - 1 - k;
    logic [NW-1:0] trial;
    logic [NW-1:0] rem_d;
    logic [QN-1:0] quo_d;

    always_comb begin
      trial = NW'(dv_den_q[k]) << BI;
      if (dv_rem_q[k] >= trial) begin
        rem_d = dv_rem_q[k] - trial;
        quo_d = dv_quo_q[k] | (QN'(1) << BI);
      end else begin
        rem_d = dv_rem_q[k];
        quo_d = dv_quo_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_rem_q[k+1] <= rem_d;
        dv_quo_q[k+1] <= quo_d;
        dv_den_q[k+1] <= dv_den_q[k];
        dv_res_q[k+1] <= dv_res_q[k];
      end
    end
  end

  // ---------------- output register ----------------
  res_t                 fin;
  logic [QN-1:0]        qs;
  logic signed [PW-1:0] px_d, py_d, px_q, py_q;
  logic signed [DW-1:0] dx_d, dy_d, dz_d, dx_q, dy_q, dz_q;

  always_comb begin
    fin = dv_res_q[QN];
    if (fin.dz) begin
      qs = '0;
    end else if (fin.neg) begin
      qs = -dv_quo_q[QN];
    end else begin
      qs = dv_quo_q[QN];
    end
    dx_d = '0;
    dy_d = fin.refl ? NONE_D : ONE_D;
    dz_d = '0;
    if (fin.op == OP_SQUARE) begin
      if (fin.sel) begin
        px_d = qs;
        py_d = fin.fixed;
      end else begin
        px_d = fin.fixed;
        py_d = qs;
      end
    end else begin
      px_d = fin.rpx;
      py_d = fin.rpy;
      if (fin.ring_ok) begin
        dx_d = fin.rdx;
        dy_d = fin.refl ? -fin.cb : fin.cb;
        dz_d = fin.rdz;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      px_q <= px_d;
      py_q <= py_d;
      dx_q <= dx_d;
      dy_q <= dy_d;
      dz_q <= dz_d;
    end
  end

  assign res_o.valid = out_vld_q;
  assign res_o.pos_x = px_q;
  assign res_o.pos_y = py_q;
  assign res_o.dir_x = dx_q;
  assign res_o.dir_y = dy_q;
  assign res_o.dir_z = dz_q;

`ifndef SYNTHESIS
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.ready) |-> !vtx_i.ready)
    else $error("input accepted while output stalled");

  a_cordic_to_round: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && cvld_q[NS]) |=> p3_vld_q)
    else $error("item lost leaving the CORDIC stages");

  a_prod_to_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && p4_vld_q) |=> dvld_q[0])
    else $error("item lost entering the divider");
`endif

endmodule

`default_nettype wire
